FILE: sv/wbd_pkg.sv
// ============================================================================
// wbd_pkg: shared types and constants for the window breakout detector
// Price width, history depth, configuration reset value, the classified item
// passed from the front end to the back end, and the back end state codes.
// ============================================================================
package wbd_pkg;

    localparam int MAX_WINDOW  = 64;
    localparam int PRICE_BITS  = 32;
    localparam int SLOT_BITS   = $clog2(MAX_WINDOW);
    localparam int CNT_BITS    = $clog2(MAX_WINDOW + 1);
    localparam int WL_BITS     = 7;
    localparam int WL_RESET    = 20;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef logic [PRICE_BITS-1:0] t_price;

    // One bar after classification by the front end.
    typedef struct packed {
        t_price                bar_high;
        t_price                bar_low;
        t_price                bar_close;
        logic [SLOT_BITS-1:0]  slot;
        logic [CNT_BITS-1:0]   win_len;
        logic                  full;
    } t_item;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DRAIN,
        BK_DONE
    } t_back_state;

endpackage

FILE: sv/wbd_ram.sv
// ============================================================================
// wbd_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ============================================================================
module wbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: sv/wbd_front.sv
// ============================================================================
// wbd_front: bar intake and classification
// Holds the window length register, tracks the store slot and the number of
// bars seen, and tags each accepted bar before it enters the queue.
// ============================================================================
module wbd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_wr_en,
    input  logic [wbd_pkg::WL_BITS-1:0]   i_cfg_wr_data,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  wbd_pkg::t_price               i_bar_high,
    input  wbd_pkg::t_price               i_bar_low,
    input  wbd_pkg::t_price               i_bar_close,
    input  logic                          i_q_full,
    output logic                          o_push,
    output wbd_pkg::t_item                o_item
);

    import wbd_pkg::*;

    logic [WL_BITS-1:0]   r_win_len;
    logic [SLOT_BITS-1:0] r_slot;
    logic [SLOT_BITS-1:0] n_slot;
    logic [CNT_BITS-1:0]  r_bars_seen;
    logic [CNT_BITS-1:0]  n_bars_seen;
    logic [CNT_BITS-1:0]  eff_len;
    logic                 accept;

    // A length of zero scans one bar; lengths past the store depth saturate.
    always_comb begin
        if (r_win_len == '0) begin
            eff_len = CNT_BITS'(1);
        end else if (int'(r_win_len) > MAX_WINDOW) begin
            eff_len = CNT_BITS'(MAX_WINDOW);
        end else begin
            eff_len = CNT_BITS'(r_win_len);
        end
    end

    assign accept = i_valid && !i_q_full;
    assign o_stall = i_q_full;
    assign o_push = accept;

    always_comb begin
        o_item.bar_high  = i_bar_high;
        o_item.bar_low   = i_bar_low;
        o_item.bar_close = i_bar_close;
        o_item.slot      = r_slot;
        o_item.win_len   = eff_len;
        o_item.full      = (r_bars_seen >= eff_len);
    end

    always_comb begin
        n_slot      = r_slot;
        n_bars_seen = r_bars_seen;
        if (accept) begin
            n_slot = (int'(r_slot) == MAX_WINDOW - 1) ? '0 : r_slot + 1'b1;
            if (r_bars_seen != CNT_BITS'(MAX_WINDOW)) begin
                n_bars_seen = r_bars_seen + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win_len   <= WL_BITS'(WL_RESET);
            r_slot      <= '0;
            r_bars_seen <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_win_len <= i_cfg_wr_data;
            end
            r_slot      <= n_slot;
            r_bars_seen <= n_bars_seen;
        end
    end

endmodule

FILE: sv/wbd_queue.sv
// ============================================================================
// wbd_queue: short item queue between front and back end
// A small register FIFO so that intake and scanning stall independently.
// ============================================================================
module wbd_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  wbd_pkg::t_item i_item,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output wbd_pkg::t_item o_item
);

    import wbd_pkg::*;

    t_item                r_slots [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_count;
    logic                 do_push;
    logic                 do_pop;

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_item  = r_slots[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (int'(r_wr_ptr) == QUEUE_DEPTH - 1) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (int'(r_rd_ptr) == QUEUE_DEPTH - 1) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_item;
        end
    end

endmodule

FILE: sv/wbd_back.sv
// ============================================================================
// wbd_back: window scan and breakout decision
// Reads the earlier bars from the history RAM one per cycle, keeps the
// running high and low, decides the break, stores the bar and registers the
// result for the output channel.
// ============================================================================
module wbd_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_empty,
    input  wbd_pkg::t_item  i_item,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_stall,
    output wbd_pkg::t_price o_break_level,
    output logic            o_bullish_break,
    output logic            o_bearish_break,
    output logic            o_window_full
);

    import wbd_pkg::*;

    t_back_state          r_state;
    t_back_state          n_state;
    t_item                r_item;
    logic [CNT_BITS-1:0]  r_k;
    logic [CNT_BITS-1:0]  n_k;
    logic                 r_rd_valid;
    t_price               r_win_hi;
    t_price               r_win_lo;
    t_price               fold_hi;
    t_price               fold_lo;
    logic                 r_out_valid;
    logic                 n_out_valid;
    t_price               r_out_level;
    logic                 r_out_bull;
    logic                 r_out_bear;
    logic                 r_out_full;
    logic                 load_item;
    logic                 load_out;
    logic                 out_free;
    logic                 rd_en;
    logic [SLOT_BITS-1:0] rd_addr;
    logic [2*PRICE_BITS-1:0] rd_data;
    t_price               rd_hi;
    t_price               rd_lo;
    logic                 bull;
    logic                 bear;
    int                   slot_diff;

    wbd_ram #(
        .WIDTH (2 * PRICE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_history (
        .i_clk     (i_clk),
        .i_wr_en   (load_out),
        .i_wr_addr (r_item.slot),
        .i_wr_data ({r_item.bar_high, r_item.bar_low}),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    assign rd_hi = rd_data[2*PRICE_BITS-1:PRICE_BITS];
    assign rd_lo = rd_data[PRICE_BITS-1:0];

    // Slot of the k-th bar before this one, wrapping around the ring.
    always_comb begin
        slot_diff = int'(r_item.slot) - int'(r_k);
        if (slot_diff < 0) begin
            slot_diff = slot_diff + MAX_WINDOW;
        end
        rd_addr = SLOT_BITS'(slot_diff);
    end

    assign fold_hi = (r_rd_valid && (rd_hi > r_win_hi)) ? rd_hi : r_win_hi;
    assign fold_lo = (r_rd_valid && (rd_lo < r_win_lo)) ? rd_lo : r_win_lo;

    assign bull = r_item.full && (r_item.bar_close > r_win_hi) && (r_win_hi != '0);
    assign bear = r_item.full && !bull && (r_item.bar_close < r_win_lo)
                  && (r_win_lo != '0);

    assign out_free = !r_out_valid || !i_stall;

    always_comb begin
        n_state   = r_state;
        n_k       = r_k;
        load_item = 1'b0;
        load_out  = 1'b0;
        rd_en     = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    load_item = 1'b1;
                    n_k       = CNT_BITS'(1);
                    n_state   = i_item.full ? BK_SCAN : BK_DONE;
                end
            end
            BK_SCAN: begin
                rd_en = 1'b1;
                n_k   = r_k + 1'b1;
                if (r_k == r_item.win_len) begin
                    n_state = BK_DRAIN;
                end
            end
            BK_DRAIN: begin
                n_state = BK_DONE;
            end
            BK_DONE: begin
                if (out_free) begin
                    load_out = 1'b1;
                    n_state  = BK_IDLE;
                end
            end
            default: begin
                n_state = BK_IDLE;
            end
        endcase
    end

    assign o_pop = load_item;
    assign n_out_valid = load_out || (r_out_valid && i_stall);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_k         <= '0;
            r_rd_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_k         <= n_k;
            r_rd_valid  <= rd_en;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_item) begin
            r_item   <= i_item;
            r_win_hi <= '0;
            r_win_lo <= '1;
        end else begin
            r_win_hi <= fold_hi;
            r_win_lo <= fold_lo;
        end
        if (load_out) begin
            r_out_bull  <= bull;
            r_out_bear  <= bear;
            r_out_full  <= r_item.full;
            r_out_level <= bull ? r_win_hi : (bear ? r_win_lo : '0);
        end
    end

    assign o_valid         = r_out_valid;
    assign o_break_level   = r_out_level;
    assign o_bullish_break = r_out_bull;
    assign o_bearish_break = r_out_bear;
    assign o_window_full   = r_out_full;

endmodule

FILE: sv/window_breakout_detector_top.sv
// ============================================================================
// window_breakout_detector_top: price channel breakout detector
// Flags closes that break the highest high or lowest low of earlier bars.
// ============================================================================
// Each item is one price bar. The result is compared against the N bars
// before it (N from the window length register, zero read as one, capped at
// 64). A bar whose window is full is scanned in the back end through the
// single read port of the history RAM, which delivers one earlier bar per
// cycle; a bar that arrives before N earlier bars have been seen skips the
// scan and reports no break. A two-entry queue in front of the scan lets
// new bars be accepted while a scan is running, and the output register lets
// the next scan proceed while a result waits to be taken. The history RAM
// needs no clearing after reset: only bars already stored are ever scanned.
module window_breakout_detector_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_wr_en,
    input  logic [wbd_pkg::WL_BITS-1:0] i_cfg_wr_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  wbd_pkg::t_price             i_bar_high,
    input  wbd_pkg::t_price             i_bar_low,
    input  wbd_pkg::t_price             i_bar_close,
    output logic                        o_valid,
    input  logic                        i_stall,
    output wbd_pkg::t_price             o_break_level,
    output logic                        o_bullish_break,
    output logic                        o_bearish_break,
    output logic                        o_window_full
);

    import wbd_pkg::*;

    t_item q_in_item;
    t_item q_out_item;
    logic  q_push;
    logic  q_full;
    logic  q_pop;
    logic  q_empty;

    wbd_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_bar_high    (i_bar_high),
        .i_bar_low     (i_bar_low),
        .i_bar_close   (i_bar_close),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_item        (q_in_item)
    );

    wbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_item  (q_in_item),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_item  (q_out_item)
    );

    wbd_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_q_empty       (q_empty),
        .i_item          (q_out_item),
        .o_pop           (q_pop),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_break_level   (o_break_level),
        .o_bullish_break (o_bullish_break),
        .o_bearish_break (o_bearish_break),
        .o_window_full   (o_window_full)
    );

    // A bar never breaks both sides at once.
    a_one_side: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !(o_bullish_break && o_bearish_break))
        else $error("bullish and bearish break flagged together");

    // No break is reported before the window has filled.
    a_break_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_bullish_break || o_bearish_break)) |-> o_window_full)
        else $error("break flagged with window not full");

    // The level is zero exactly when there is no break.
    a_level_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_bullish_break && !o_bearish_break) |-> (o_break_level == '0))
        else $error("nonzero break level without a break");

    // The scan never pops from an empty queue.
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb: self-checking testbench for the window breakout detector
// Drives price bars through the valid/stall input channel and predicts each
// verdict with a local model of the history rings and the window scan.
// Every result taken from the output channel is compared with the oldest
// prediction. The run moves through several window lengths and idle patterns.
// ============================================================================
module tb;
    import wbd_pkg::*;

    localparam int CLK_HALF     = 5;
    localparam int SCAN_LATENCY = MAX_WINDOW + 8;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        t_price level;
        logic   bull;
        logic   bear;
        logic   full;
    } t_verdict;

    // Keeps its own copy of the history rings and predicts one verdict per bar.
    class t_breakout_predictor;
        t_price      high_ring [MAX_WINDOW];
        t_price      low_ring  [MAX_WINDOW];
        int unsigned next_slot;
        int unsigned stored_bars;
        int unsigned window_bars;
        t_verdict    verdict_q [$];
        int unsigned mismatches;

        function new();
            next_slot   = 0;
            stored_bars = 0;
            window_bars = WL_RESET;
            mismatches  = 0;
        endfunction

        function void set_window(logic [WL_BITS-1:0] value);
            if (value == 0)
                window_bars = 1;
            else if (value > MAX_WINDOW)
                window_bars = MAX_WINDOW;
            else
                window_bars = 32'(value);
        endfunction

        function void add_bar(t_price bar_hi, t_price bar_lo, t_price bar_cl);
            t_verdict    v;
            t_price      top;
            t_price      bottom;
            int unsigned s;
            v.level = '0;
            v.bull  = 1'b0;
            v.bear  = 1'b0;
            v.full  = (stored_bars >= window_bars);
            if (v.full) begin
                top    = '0;
                bottom = '1;
                for (int k = 1; k <= window_bars; k++) begin
                    s = (next_slot + MAX_WINDOW - k) % MAX_WINDOW;
                    if (high_ring[s] > top)
                        top = high_ring[s];
                    if (low_ring[s] < bottom)
                        bottom = low_ring[s];
                end
                // A zero level on either side never counts as a break.
                if (bar_cl > top && top != 0) begin
                    v.bull  = 1'b1;
                    v.level = top;
                end else if (bar_cl < bottom && bottom != 0) begin
                    v.bear  = 1'b1;
                    v.level = bottom;
                end
            end
            high_ring[next_slot] = bar_hi;
            low_ring[next_slot]  = bar_lo;
            next_slot = (next_slot + 1) % MAX_WINDOW;
            if (stored_bars < MAX_WINDOW)
                stored_bars++;
            verdict_q = {verdict_q, v};
        endfunction

        function void check_verdict(t_price level, logic bull, logic bear, logic full);
            t_verdict want;
            if (verdict_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: unexpected result: level %h bull %b bear %b full %b",
                             $time, level, bull, bear, full);
                return;
            end
            want = verdict_q.pop_front();
            if (level !== want.level || bull !== want.bull ||
                bear !== want.bear || full !== want.full) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("%0t: expected %h/%b/%b/%b, got %h/%b/%b/%b",
                             $time, want.level, want.bull, want.bear, want.full,
                             level, bull, bear, full);
            end
        endfunction
    endclass

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_wr_en = 1'b0;
    logic [WL_BITS-1:0]  i_cfg_wr_data = '0;
    logic                i_valid = 1'b0;
    logic                o_stall;
    t_price              i_bar_high = '0;
    t_price              i_bar_low = '0;
    t_price              i_bar_close = '0;
    logic                o_valid;
    logic                i_stall = 1'b0;
    t_price              o_break_level;
    logic                o_bullish_break;
    logic                o_bearish_break;
    logic                o_window_full;

    t_breakout_predictor bars_model;
    int                  idle_pct = 0;
    int                  stall_pct = 0;
    int                  hold_request = 0;
    int                  hold_left = 0;
    longint              walk_base = 64'h0400_0000;
    t_price              last_high = 32'h0400_0000;
    t_price              last_low = 32'h0400_0000;

    window_breakout_detector_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_wr_en     (i_cfg_wr_en),
        .i_cfg_wr_data   (i_cfg_wr_data),
        .i_valid         (i_valid),
        .o_stall         (o_stall),
        .i_bar_high      (i_bar_high),
        .i_bar_low       (i_bar_low),
        .i_bar_close     (i_bar_close),
        .o_valid         (o_valid),
        .i_stall         (i_stall),
        .o_break_level   (o_break_level),
        .o_bullish_break (o_bullish_break),
        .o_bearish_break (o_bearish_break),
        .o_window_full   (o_window_full)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // Output side: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_request > 0) begin
            hold_left    = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            bars_model.check_verdict(o_break_level, o_bullish_break,
                                     o_bearish_break, o_window_full);
    end

    // Valid stays high from one item to the next unless an idle cycle is rolled.
    task automatic send_bar(input t_price bar_hi, input t_price bar_lo, input t_price bar_cl);
        @(negedge i_clk);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_bar_high  <= bar_hi;
        i_bar_low   <= bar_lo;
        i_bar_close <= bar_cl;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        bars_model.add_bar(bar_hi, bar_lo, bar_cl);
    endtask

    task automatic stop_sending();
        @(negedge i_clk);
        i_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (bars_model.verdict_q.size() != 0)
            @(posedge i_clk);
        repeat (SCAN_LATENCY) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [WL_BITS-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        bars_model.set_window(value);
    endtask

    function automatic t_price edge_price();
        case ($urandom_range(2))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Mostly a slow random walk with breakouts, ties and plain inside bars;
    // a few bars use fully random or extreme prices.
    task automatic make_bar(output t_price bar_hi, output t_price bar_lo, output t_price bar_cl);
        int unsigned pick;
        int unsigned spread;
        int unsigned margin;
        pick   = $urandom_range(99);
        spread = $urandom_range(1, 1 << 18);
        margin = $urandom_range(1, 1 << 18);
        if (pick < 8) begin
            bar_hi = $urandom;
            bar_lo = $urandom;
            bar_cl = $urandom;
        end else if (pick < 12) begin
            bar_hi = edge_price();
            bar_lo = edge_price();
            bar_cl = edge_price();
        end else begin
            walk_base += longint'($urandom_range(0, 1 << 17)) - (1 << 16);
            if (walk_base < 64'h0100_0000)
                walk_base = 64'h0100_0000;
            if (walk_base > 64'h8000_0000)
                walk_base = 64'h8000_0000;
            bar_hi = t_price'(walk_base + spread);
            bar_lo = t_price'(walk_base - spread);
            pick   = $urandom_range(99);
            if (pick < 20)
                bar_cl = bar_hi + margin;
            else if (pick < 40)
                bar_cl = bar_lo - margin;
            else if (pick < 48)
                bar_cl = last_high;
            else if (pick < 56)
                bar_cl = last_low;
            else
                bar_cl = bar_lo + $urandom_range(0, 2 * spread);
        end
        last_high = bar_hi;
        last_low  = bar_lo;
    endtask

    task automatic run_phase(input logic [WL_BITS-1:0] wl, input int idle, input int stall,
                             input int count, input bit pressure);
        t_price bar_hi;
        t_price bar_lo;
        t_price bar_cl;
        stop_sending();
        wait_drained();
        write_window(wl);
        idle_pct  = idle;
        stall_pct = stall;
        if (pressure)
            hold_request = HOLD_CYCLES;
        for (int n = 0; n < count; n++) begin
            // Halfway through, let the block empty completely before going on.
            if (pressure && n == count / 2) begin
                stop_sending();
                while (bars_model.verdict_q.size() != 0)
                    @(posedge i_clk);
            end
            make_bar(bar_hi, bar_lo, bar_cl);
            send_bar(bar_hi, bar_lo, bar_cl);
        end
    endtask

    initial begin
        #(10_000_000);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        bars_model = new();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Reset window of 20: these bars can only report a window that is not full.
        send_bar(32'h0010_0000, 32'h000F_0000, 32'hFFFF_FFFF);
        send_bar(32'h0000_0001, 32'h0000_0001, 32'h0000_0000);
        send_bar(32'h0012_0000, 32'h0011_0000, 32'h0011_8000);

        // A zero length acts as one, so each bar is judged against the one before.
        stop_sending();
        wait_drained();
        write_window(0);
        send_bar(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF);
        send_bar(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_bar(32'h0000_0100, 32'h0000_0050, 32'hFFFF_FFFF);
        send_bar(32'h0000_0200, 32'h0000_0100, 32'h0000_0101);
        send_bar(32'h0000_0200, 32'h0000_0100, 32'h0000_0099);
        send_bar(32'h0000_0200, 32'h0000_0100, 32'h0000_0200);
        send_bar(32'h0000_0200, 32'h0000_0100, 32'h0000_0100);
        send_bar(32'h8000_0000, 32'h0000_0001, 32'h0000_0000);
        send_bar(32'h0000_0001, 32'h0000_0001, 32'h0000_0000);
        send_bar(32'hFFFF_FFFF, 32'h0000_0002, 32'h0000_0001);
        send_bar(32'h0000_0003, 32'h0000_0000, 32'hFFFF_FFFF);

        // Lengths above the ring depth saturate; the history so far is too short.
        stop_sending();
        wait_drained();
        write_window(127);
        send_bar(32'h0000_0400, 32'h0000_0300, 32'h0000_0350);
        send_bar(32'h0000_0500, 32'h0000_0001, 32'hFFFF_FFFF);

        run_phase(1,   0,  0,  100, 1'b0);
        run_phase(64,  77, 0,  120, 1'b0);
        run_phase(2,   0,  77, 120, 1'b0);
        run_phase(127, 24, 24, 120, 1'b0);
        run_phase(5,   0,  0,  100, 1'b1);
        run_phase(65,  0,  0,  60,  1'b0);
        run_phase(WL_BITS'($urandom_range(1, MAX_WINDOW)), 24, 24, 100, 1'b0);
        run_phase(3,   0,  77, 100, 1'b0);
        run_phase(0,   24, 24, 80,  1'b0);

        stop_sending();
        wait_drained();
        if (bars_model.mismatches == 0 && bars_model.verdict_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
